FILE: hw/rtl/bcc_pkg.sv
// Shared types and constants for the block claim checker.
package bcc_pkg;

	localparam int BLOCK_W         = 24;
	localparam int COUNT_W         = 16;
	localparam int NUM_WATCH       = 5;
	localparam int CFG_INDEX_W     = 3;
	localparam int BITMAP_BLOCKS_DEF = 65536;

	localparam logic [BLOCK_W-1:0] FIRST_DATA_RST = 24'd2;
	localparam logic [BLOCK_W-1:0] VOLUME_RST     = 24'd65538;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_FIRST_DATA = 3'd0,
		REG_VOLUME     = 3'd1,
		REG_DUP_OFF    = 3'd2,
		REG_WATCH_A    = 3'd3,
		REG_WATCH_B    = 3'd4,
		REG_WATCH_C    = 3'd5,
		REG_WATCH_D    = 3'd6,
		REG_WATCH_E    = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_DUP   = 2'd2
	} status_t;

	typedef struct packed {
		logic [BLOCK_W-1:0]                first_data;
		logic [BLOCK_W-1:0]                volume;
		logic                              dup_off;
		logic [NUM_WATCH-1:0][BLOCK_W-1:0] watch;
	} cfg_t;

endpackage

FILE: hw/rtl/block_claim_checker.sv
// Block claim checker top level: range check, bitmap duplicate detection, watch match.
//
// One word in, one word out. A claim enters the first stage on acceptance, where the range
// check and watch compare are done and the bitmap byte is read; the second stage tests and
// sets the bit, writes the byte back and loads the output register once the output is free,
// so a result is held in the stage-one registers and then the output register. A new word
// is taken every cycle while the output is drained; the last written byte is forwarded so
// back-to-back claims on the same byte see it. The bitmap is a single-port-write,
// single-read memory of (BITMAP_BLOCKS+7)/8 bytes; after reset it is swept clear one byte per
// cycle (8192 bytes at the default size), and s_tready stays low until the sweep ends.
// Configuration writes are taken at any time.
module block_claim_checker
	import bcc_pkg::*;
#(
	parameter int BITMAP_BLOCKS = BITMAP_BLOCKS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// claim words
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [23:0]            s_tdata,   // [23:0] block_number
	// result words
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [23:0]            m_tdata,   // [1:0] status, [2] watched, [18:3] dup_total
	// configuration
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [BLOCK_W-1:0]     cfg_data
);

	localparam int MAP_BYTES = (BITMAP_BLOCKS + 7) / 8;
	localparam int ADDR_W    = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;

	cfg_t cfg;

	bcc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	logic [7:0] bitmap_mem [MAP_BYTES];

	logic              clearing_q;
	logic [ADDR_W-1:0] clr_addr_q;

	logic              valid_s1;
	logic              bad_s1;
	logic              watch_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [2:0]        bit_s1;
	logic [7:0]        rdata_q;

	logic              fwd_valid_q;
	logic [ADDR_W-1:0] fwd_addr_q;
	logic [7:0]        fwd_data_q;

	logic               m_valid_q;
	status_t            status_q;
	logic               watched_q;
	logic [COUNT_W-1:0] dup_cnt_q;

	// accept side
	logic [BLOCK_W-1:0] bno;
	logic [BLOCK_W-1:0] offset;
	logic               bad_in;
	logic               watch_in;
	logic               accept;
	logic               advance_s1;

	always_comb begin
		bno      = s_tdata;
		offset   = bno - cfg.first_data;
		bad_in   = (bno < cfg.first_data) || (bno >= cfg.volume) ||
		           ({1'b0, offset} >= (BLOCK_W+1)'(BITMAP_BLOCKS));
		watch_in = 1'b0;
		for (int i = 0; i < NUM_WATCH; i++) begin
			if (cfg.watch[i] != '0 && cfg.watch[i] == bno)
				watch_in = 1'b1;
		end
	end

	assign advance_s1 = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready   = !clearing_q && (!valid_s1 || advance_s1);
	assign accept     = s_tvalid && s_tready;

	// test and set
	logic [7:0] cur_byte;
	logic [7:0] new_byte;
	logic       check;
	logic       dup;

	always_comb begin
		cur_byte = (fwd_valid_q && fwd_addr_q == addr_s1) ? fwd_data_q : rdata_q;
		new_byte = cur_byte | (8'd1 << bit_s1);
		check    = !bad_s1 && !cfg.dup_off;
		dup      = check && cur_byte[bit_s1];
	end

	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [7:0]        wr_data;

	assign wr_en   = clearing_q || (advance_s1 && check);
	assign wr_addr = clearing_q ? clr_addr_q : addr_s1;
	assign wr_data = clearing_q ? 8'd0 : new_byte;

	always_ff @(posedge clk) begin
		if (wr_en)
			bitmap_mem[wr_addr] <= wr_data;
		if (accept)
			rdata_q <= bitmap_mem[offset[ADDR_W+2:3]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			if (clr_addr_q == ADDR_W'(MAP_BYTES - 1))
				clearing_q <= 1'b0;
			clr_addr_q <= clr_addr_q + ADDR_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			fwd_valid_q <= 1'b0;
			m_valid_q   <= 1'b0;
			dup_cnt_q   <= '0;
		end else begin
			if (accept)
				valid_s1 <= 1'b1;
			else if (advance_s1)
				valid_s1 <= 1'b0;

			if (advance_s1) begin
				fwd_valid_q <= check;
				m_valid_q   <= 1'b1;
				if (dup && dup_cnt_q != '1)
					dup_cnt_q <= dup_cnt_q + COUNT_W'(1);
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bad_s1   <= bad_in;
			watch_s1 <= watch_in && !bad_in;
			addr_s1  <= offset[ADDR_W+2:3];
			bit_s1   <= offset[2:0];
		end
		if (advance_s1) begin
			fwd_addr_q <= addr_s1;
			fwd_data_q <= new_byte;
			watched_q  <= watch_s1;
			priority if (bad_s1)
				status_q <= ST_RANGE;
			else if (dup)
				status_q <= ST_DUP;
			else
				status_q <= ST_OK;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {5'd0, dup_cnt_q, watched_q, status_q};

endmodule

FILE: hw/rtl/bcc_cfg.sv
// Configuration register file for the block claim checker.
module bcc_cfg
	import bcc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [BLOCK_W-1:0]     cfg_data,
	output cfg_t                   cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.first_data <= FIRST_DATA_RST;
			cfg_q.volume     <= VOLUME_RST;
			cfg_q.dup_off    <= 1'b0;
			cfg_q.watch      <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_FIRST_DATA: cfg_q.first_data <= cfg_data;
				REG_VOLUME:     cfg_q.volume     <= cfg_data;
				REG_DUP_OFF:    cfg_q.dup_off    <= cfg_data[0];
				REG_WATCH_A:    cfg_q.watch[0]   <= cfg_data;
				REG_WATCH_B:    cfg_q.watch[1]   <= cfg_data;
				REG_WATCH_C:    cfg_q.watch[2]   <= cfg_data;
				REG_WATCH_D:    cfg_q.watch[3]   <= cfg_data;
				REG_WATCH_E:    cfg_q.watch[4]   <= cfg_data;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: tb/block_claim_checker_tb.sv
// Testbench for block_claim_checker: directed and random claims checked against a scoreboard.
`timescale 1ns / 1ps

module block_claim_checker_tb;
	import bcc_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int PHASE_WORDS = 170;
	localparam logic [BLOCK_W-1:0] BLOCK_MAX = '1;

	typedef struct packed {
		status_t            status;
		logic               watched;
		logic [COUNT_W-1:0] dup_total;
	} claim_result_t;

	class claim_book;
		logic [BLOCK_W-1:0] first_data;
		logic [BLOCK_W-1:0] volume;
		logic               dup_off;
		logic [BLOCK_W-1:0] watch [NUM_WATCH];
		bit                 claim_map [BITMAP_BLOCKS_DEF];
		logic [COUNT_W-1:0] dup_count;
		claim_result_t      expected_q [$];
		int                 errors;

		function new();
			first_data = FIRST_DATA_RST;
			volume     = VOLUME_RST;
			dup_off    = 1'b0;
			foreach (watch[i]) watch[i] = '0;
			foreach (claim_map[i]) claim_map[i] = 1'b0;
			dup_count  = '0;
			errors     = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [BLOCK_W-1:0] v);
			case (idx)
				REG_FIRST_DATA: first_data = v;
				REG_VOLUME:     volume = v;
				REG_DUP_OFF:    dup_off = v[0];
				REG_WATCH_A, REG_WATCH_B, REG_WATCH_C, REG_WATCH_D, REG_WATCH_E:
					watch[int'(idx) - int'(REG_WATCH_A)] = v;
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// range check, bitmap test-and-set, watch compare
		function void note_claim(logic [BLOCK_W-1:0] blk);
			claim_result_t      res;
			logic [BLOCK_W-1:0] offset;
			res.status  = ST_OK;
			res.watched = 1'b0;
			if (blk < first_data || blk >= volume) begin
				res.status = ST_RANGE;
			end else begin
				offset = blk - first_data;
				if (offset >= BITMAP_BLOCKS_DEF) begin
					res.status = ST_RANGE;
				end else begin
					if (!dup_off) begin
						if (claim_map[offset]) begin
							res.status = ST_DUP;
							if (dup_count != '1)
								dup_count++;
						end
						claim_map[offset] = 1'b1;
					end
					foreach (watch[i])
						if (watch[i] != '0 && watch[i] == blk)
							res.watched = 1'b1;
				end
			end
			res.dup_total = dup_count;
			expected_q.push_back(res);
		endfunction

		task report(string what);
			errors++;
			$display("ERROR @%0t: %s", $time, what);
		endtask

		task check_result(logic [23:0] word);
			claim_result_t exp;
			if (expected_q.size() == 0) begin
				report($sformatf("result word %h with nothing expected", word));
				return;
			end
			exp = expected_q.pop_front();
			if (word[1:0] !== exp.status)
				report($sformatf("status %0d, expected %s", word[1:0], exp.status.name()));
			if (word[2] !== exp.watched)
				report($sformatf("watched %b, expected %b", word[2], exp.watched));
			if (word[18:3] !== exp.dup_total)
				report($sformatf("dup_total %0d, expected %0d", word[18:3], exp.dup_total));
		endtask
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [23:0]            s_tdata = '0;   // [23:0] block_number
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [23:0]            m_tdata;        // [1:0] status, [2] watched, [18:3] dup_total
	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [BLOCK_W-1:0]     cfg_data = '0;

	claim_book book = new();
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int cycles = 0;

	logic [BLOCK_W-1:0]                cur_first;
	logic [BLOCK_W-1:0]                cur_volume;
	logic [NUM_WATCH-1:0][BLOCK_W-1:0] cur_watch;

	block_claim_checker uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles >= CYCLE_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// result side: check accepted words, random backpressure
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready)
				book.check_result(m_tdata);
			m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	task send_claim(input logic [BLOCK_W-1:0] blk);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= blk;
		do @(posedge clk); while (!s_tready);
		book.note_claim(blk);
	endtask

	task settle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (book.pending() != 0);
		repeat (4) @(posedge clk);
	endtask

	task apply_settings(input logic [BLOCK_W-1:0] fdb, input logic [BLOCK_W-1:0] vol,
			input logic off, input logic [NUM_WATCH-1:0][BLOCK_W-1:0] w);
		reg_idx_t           idx;
		logic [BLOCK_W-1:0] v;
		idx = idx.first();
		repeat (idx.num()) begin
			case (idx)
				REG_FIRST_DATA: v = fdb;
				REG_VOLUME:     v = vol;
				REG_DUP_OFF:    v = {{(BLOCK_W-1){1'b0}}, off};
				default:        v = w[int'(idx) - int'(REG_WATCH_A)];
			endcase
			cfg_we    <= 1'b1;
			cfg_index <= idx;
			cfg_data  <= v;
			@(posedge clk);
			book.set_reg(idx, v);
			idx = idx.next();
		end
		cfg_we <= 1'b0;
		cur_first  = fdb;
		cur_volume = vol;
		cur_watch  = w;
	endtask

	function automatic logic [BLOCK_W-1:0] pick_block();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return cur_first + BLOCK_W'($urandom_range(0, 255));
		else if (r < 70)
			return cur_first + BLOCK_W'($urandom_range(0, BITMAP_BLOCKS_DEF + 3));
		else if (r < 78)
			return cur_watch[$urandom_range(0, NUM_WATCH - 1)];
		else if (r < 88)
			case ($urandom_range(0, 5))
				0: return cur_volume - 24'd1;
				1: return cur_volume;
				2: return cur_first - 24'd1;
				3: return cur_first;
				4: return cur_first + BLOCK_W'(BITMAP_BLOCKS_DEF - 1);
				default: return cur_first + BLOCK_W'(BITMAP_BLOCKS_DEF);
			endcase
		return BLOCK_W'($urandom());
	endfunction

	function automatic logic [BLOCK_W-1:0] clamp_volume(logic [BLOCK_W-1:0] fdb, int span);
		longint top;
		top = longint'(fdb) + span;
		return (top > longint'(BLOCK_MAX)) ? BLOCK_MAX : BLOCK_W'(top);
	endfunction

	initial begin
		logic [NUM_WATCH-1:0][BLOCK_W-1:0] w;
		logic [BLOCK_W-1:0]                fdb;
		logic [BLOCK_W-1:0]                vol;
		logic                              off;

		cur_first  = FIRST_DATA_RST;
		cur_volume = VOLUME_RST;
		cur_watch  = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: below first block, first claim, duplicate, top of volume
		send_claim(24'd0);
		send_claim(24'd1);
		send_claim(24'd2);
		send_claim(24'd2);
		send_claim(24'd65537);
		send_claim(24'd65538);
		send_claim(BLOCK_MAX);
		settle();

		// watches, one below the data area and one past the volume
		w = '{BLOCK_MAX, 24'd0, 24'd1, 24'd65537, 24'd5};
		apply_settings(FIRST_DATA_RST, VOLUME_RST, 1'b0, w);
		send_claim(24'd5);
		send_claim(24'd65537);
		send_claim(24'd1);
		send_claim(BLOCK_MAX);
		settle();

		// new base over the old bitmap; claims past bitmap capacity
		apply_settings('0, BLOCK_MAX, 1'b0, '0);
		send_claim(24'd0);
		send_claim(24'd65535);
		send_claim(24'd65536);
		send_claim(BLOCK_MAX - 24'd1);
		settle();

		// dup check off leaves the bitmap alone
		w = '{24'd0, 24'd0, 24'd0, 24'd0, 24'd7};
		apply_settings('0, BLOCK_MAX, 1'b1, w);
		send_claim(24'd0);
		send_claim(24'd7);
		settle();
		apply_settings('0, BLOCK_MAX, 1'b0, w);
		send_claim(24'd7);
		send_claim(24'd7);
		settle();

		for (int phase = 0; phase < 9; phase++) begin
			send_idle_pct = (phase < 3) ? 27 : (phase < 6) ? 64 : 0;
			recv_idle_pct = (phase < 3) ? 64 : (phase < 6) ? 27 : 0;
			fdb = BLOCK_W'($urandom_range(0, 200000));
			vol = clamp_volume(fdb, $urandom_range(1, 80000));
			off = 1'b0;
			case (phase)
				0, 8: begin
					fdb = FIRST_DATA_RST;
					vol = VOLUME_RST;
				end
				1: begin
					fdb = '0;
					vol = BLOCK_MAX;
				end
				3: begin
					fdb = BLOCK_MAX;
					vol = '0;
				end
				4: off = 1'b1;
				5: vol = BLOCK_MAX;
				6: begin
					fdb = BLOCK_MAX - 24'd300;
					vol = BLOCK_MAX;
				end
				default: ;
			endcase
			foreach (w[i])
				case ($urandom_range(0, 2))
					0: w[i] = '0;
					1: w[i] = fdb + BLOCK_W'($urandom_range(0, 255));
					default: w[i] = BLOCK_W'($urandom());
				endcase
			apply_settings(fdb, vol, off, w);
			for (int k = 0; k < PHASE_WORDS; k++) begin
				send_claim(pick_block());
				if (phase == 1 && k == PHASE_WORDS / 2)
					settle();
			end
			settle();
		end

		repeat (10) @(posedge clk);

		if (book.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

FILE: block_claim_checker.f
hw/rtl/bcc_pkg.sv
hw/rtl/bcc_cfg.sv
hw/rtl/block_claim_checker.sv
tb/block_claim_checker_tb.sv
